FILE: src/pnz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pnz_pkg;

  // parameter defaults
  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  // item fields
  localparam int HASH_W  = 8;
  localparam int COORD_W = 32;
  localparam int OUT_W   = 20;
  localparam int OUT_FRAC = 16;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // gradient codes whose second term takes x (their first term takes y)
  localparam logic [3:0] GRAD_XX_A = 4'd12;
  localparam logic [3:0] GRAD_XX_B = 4'd14;

  // fade polynomial coefficients
  localparam int FADE_C6  = 6;
  localparam int FADE_C15 = 15;
  localparam int FADE_C10 = 10;

  // sequencer
  localparam int STEP_W    = 5;
  localparam int LAST_STEP = 18;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } pnz_state_t;

endpackage

`default_nettype wire

FILE: src/perlin_noise_eval.sv
`timescale 1ns / 1ps
`default_nettype none

// 2-d improved gradient noise (z = 0 face of the 3-d scheme), fixed point
//
// input channel (in_valid / in_stall): one word per item
//   cmd = load: writes table_value into the permutation table at table_index;
//     the input does not stall for it, and it gives no result
//   cmd = eval: samples noise at (x_coord, y_coord), signed Q15.16; gives one
//     noise_value word, signed Q3.16, saturated
// output channel (out_valid / out_stall): one result word per eval
//
// an eval: the input stalls while it runs, so the block takes no new word
//   until its result has gone to the output register; the run is set by
//   the single table port: ten table reads, one per cycle, chained three
//   deep, followed by the three lerps through the shared multiplier (fades
//   overlap with the table reads)
// a finished result waits in the output register; the block already takes
//   the next word, and only a second eval finishing while the first is still
//   stalled holds the sequencer until the output frees up
// reset clears the sequencer and out_valid; the table is not cleared, every
//   entry an eval touches must have been loaded first
module perlin_noise_eval
  #(
  parameter int TABLE_SIZE = pnz_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = pnz_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               cmd,
  input  wire logic [pnz_pkg::HASH_W-1:0]         table_index,
  input  wire logic [pnz_pkg::HASH_W-1:0]         table_value,
  input  wire logic signed [pnz_pkg::COORD_W-1:0] x_coord,
  input  wire logic signed [pnz_pkg::COORD_W-1:0] y_coord,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [pnz_pkg::OUT_W-1:0]        noise_value
);

  import pnz_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  // working width: signed, holds values within [-32, 32) in FRAC_BITS fixed point
  localparam int W  = FRAC_BITS + 6;
  localparam int PW = 2 * W;
  localparam int WE = W + OUT_FRAC;

  localparam logic signed [W-1:0]  ONE_Q     = W'(1) <<< FRAC_BITS;
  localparam logic signed [W-1:0]  FIFTEEN_Q = W'(FADE_C15) <<< FRAC_BITS;
  localparam logic signed [W-1:0]  TEN_Q     = W'(FADE_C10) <<< FRAC_BITS;
  localparam logic signed [PW-1:0] P_HALF    = PW'(1) <<< (FRAC_BITS - 1);

  // rescale to the output fraction
  localparam int SHL = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
  localparam int SHR = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam logic signed [WE-1:0] OUT_HALF = WE'(2 ** SHR) >>> 1;
  localparam logic signed [WE-1:0] OUT_MAX_E = WE'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [WE-1:0] OUT_MIN_E = -WE'(2 ** (OUT_W - 1));

  function automatic logic [IW-1:0] to_idx(input logic [HASH_W-1:0] v);
    logic [IW+HASH_W-1:0] ext;
    begin
      ext = {{IW{1'b0}}, v};
      return ext[IW-1:0];
    end
  endfunction

  function automatic logic [IW-1:0] lattice(input logic [COORD_W-1:0] c);
    logic [COORD_W-1:0] mag;
    logic [COORD_W-1:0] ip;
    begin
      mag = c[COORD_W-1] ? (~c + COORD_W'(1)) : c;
      ip  = mag >> FRAC_BITS;
      return c[COORD_W-1] ? (IW'(0) - ip[IW-1:0]) : ip[IW-1:0];
    end
  endfunction

  function automatic logic signed [W-1:0] grad(
    input logic [HASH_W-1:0]    hv,
    input logic signed [W-1:0]  gx,
    input logic signed [W-1:0]  gy
  );
    logic [3:0]          h;
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    logic signed [W-1:0] sa;
    logic signed [W-1:0] sb;
    begin
      h = hv[3:0];
      a = h[3] ? gy : gx;
      priority if (h < 4'd4) begin
        b = gy;
      end else if (h == GRAD_XX_A || h == GRAD_XX_B) begin
        b = gx;
      end else begin
        b = '0;
      end
      sa = h[0] ? -a : a;
      sb = h[1] ? -b : b;
      return sa + sb;
    end
  endfunction

  pnz_state_t state, state_next;
  logic [STEP_W-1:0] step;

  // sample registers
  logic [IW-1:0]       ix, iy;
  logic signed [W-1:0] fx, fy, fxm, fym, sx, sy;

  // hash chain
  logic [HASH_W-1:0] ha, hb, q_aa, q_ab, q_ba, q_bb, h_aa, h_ab, h_ba, h_bb;

  // arithmetic
  logic signed [W-1:0]  t2x, t2y, ux, uy, t3x, t3y, fadex, fadey;
  logic signed [W-1:0]  g_aa, g_ab, g_ba, g_bb, d1, d2, d3, l1, l2, res;
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod, prod_adj, rnd_full;
  logic signed [W-1:0]  rnd;

  // output scaling
  logic signed [WE-1:0] res_ext, res_up, res_dn_adj, res_dn, scaled;
  logic signed [OUT_W-1:0] sat;

  // table port
  logic              ram_we;
  logic [IW-1:0]     ram_addr;
  logic [HASH_W-1:0] rdata;

  logic in_acc, out_free, is_load, is_eval;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_load  = in_acc && (cmd == CMD_LOAD);
  assign is_eval  = in_acc && (cmd == CMD_EVAL);
  assign out_free = !out_valid || !out_stall;

  assign ram_we = is_load;

  always_comb begin
    unique case (step)
      STEP_W'(0): ram_addr = ix;
      STEP_W'(1): ram_addr = ix + IW'(1);
      STEP_W'(2): ram_addr = to_idx(ha) + iy;
      STEP_W'(3): ram_addr = to_idx(ha) + iy + IW'(1);
      STEP_W'(4): ram_addr = to_idx(hb) + iy;
      STEP_W'(5): ram_addr = to_idx(hb) + iy + IW'(1);
      STEP_W'(6): ram_addr = to_idx(q_aa);
      STEP_W'(7): ram_addr = to_idx(q_ab);
      STEP_W'(8): ram_addr = to_idx(q_ba);
      STEP_W'(9): ram_addr = to_idx(q_bb);
      default:    ram_addr = ix;
    endcase
    if (state == ST_IDLE) begin
      ram_addr = to_idx(table_index);
    end
  end

  pnz_ram #(
    .WIDTH(HASH_W),
    .DEPTH(TABLE_SIZE)
  ) u_perm (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(table_value),
    .rdata(rdata)
  );

  // shared multiplier: operands by step, product registered, rounded next step
  always_comb begin
    unique case (step)
      STEP_W'(0):  begin mul_a = fx;    mul_b = fx; end
      STEP_W'(1):  begin mul_a = fy;    mul_b = fy; end
      STEP_W'(2):  begin mul_a = fx;    mul_b = sx; end
      STEP_W'(3):  begin mul_a = fy;    mul_b = sy; end
      STEP_W'(4):  begin mul_a = t2x;   mul_b = fx; end
      STEP_W'(5):  begin mul_a = t2y;   mul_b = fy; end
      STEP_W'(6):  begin mul_a = t3x;   mul_b = ux; end
      STEP_W'(7):  begin mul_a = t3y;   mul_b = uy; end
      STEP_W'(13): begin mul_a = fadex; mul_b = d1; end
      STEP_W'(14): begin mul_a = fadex; mul_b = d2; end
      STEP_W'(17): begin mul_a = fadey; mul_b = d3; end
      default:     begin mul_a = fx;    mul_b = fx; end
    endcase
  end

  // round to nearest, ties away from zero
  assign prod_adj = prod + P_HALF - PW'(prod[PW-1]);
  assign rnd_full = prod_adj >>> FRAC_BITS;
  assign rnd      = rnd_full[W-1:0];

  // rescale and saturate
  assign res_ext    = WE'(res);
  assign res_up     = res_ext <<< SHL;
  assign res_dn_adj = res_ext + OUT_HALF - WE'(res_ext[WE-1]);
  assign res_dn     = res_dn_adj >>> SHR;
  assign scaled     = (FRAC_BITS > OUT_FRAC) ? res_dn : res_up;

  always_comb begin
    priority if (scaled > OUT_MAX_E) begin
      sat = OUT_MAX_E[OUT_W-1:0];
    end else if (scaled < OUT_MIN_E) begin
      sat = OUT_MIN_E[OUT_W-1:0];
    end else begin
      sat = scaled[OUT_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (is_eval) state_next = ST_RUN;
      ST_RUN:  if (step == STEP_W'(LAST_STEP)) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RUN) begin
        step <= step + STEP_W'(1);
      end else begin
        step <= '0;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (is_eval) begin
      ix  <= lattice(x_coord);
      iy  <= lattice(y_coord);
      fx  <= W'(x_coord[FRAC_BITS-1:0]);
      fy  <= W'(y_coord[FRAC_BITS-1:0]);
      fxm <= W'(x_coord[FRAC_BITS-1:0]) - ONE_Q;
      fym <= W'(y_coord[FRAC_BITS-1:0]) - ONE_Q;
      sx  <= W'(FADE_C6) * W'(x_coord[FRAC_BITS-1:0]) - FIFTEEN_Q;
      sy  <= W'(FADE_C6) * W'(y_coord[FRAC_BITS-1:0]) - FIFTEEN_Q;
    end

    if (state == ST_RUN) begin
      prod <= mul_a * mul_b;
      unique case (step)
        STEP_W'(1):  begin ha   <= rdata; t2x <= rnd; end
        STEP_W'(2):  begin hb   <= rdata; t2y <= rnd; end
        STEP_W'(3):  begin q_aa <= rdata; ux  <= rnd + TEN_Q; end
        STEP_W'(4):  begin q_ab <= rdata; uy  <= rnd + TEN_Q; end
        STEP_W'(5):  begin q_ba <= rdata; t3x <= rnd; end
        STEP_W'(6):  begin q_bb <= rdata; t3y <= rnd; end
        STEP_W'(7):  begin h_aa <= rdata; fadex <= rnd; end
        STEP_W'(8):  begin h_ab <= rdata; fadey <= rnd; end
        STEP_W'(9):  h_ba <= rdata;
        STEP_W'(10): h_bb <= rdata;
        STEP_W'(11): begin
          g_aa <= grad(h_aa, fx,  fy);
          g_ba <= grad(h_ba, fxm, fy);
          g_ab <= grad(h_ab, fx,  fym);
          g_bb <= grad(h_bb, fxm, fym);
        end
        STEP_W'(12): begin
          d1 <= g_ba - g_aa;
          d2 <= g_bb - g_ab;
        end
        STEP_W'(14): l1  <= g_aa + rnd;
        STEP_W'(15): l2  <= g_ab + rnd;
        STEP_W'(16): d3  <= l2 - l1;
        STEP_W'(18): res <= l1 + rnd;
        default: ;
      endcase
    end

    if (state == ST_DONE && out_free) begin
      noise_value <= sat;
    end
  end

endmodule

`default_nettype wire

FILE: src/pnz_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pnz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: tb/sv/perlin_noise_eval_test.sv
`timescale 1ns / 1ps

module perlin_noise_eval_test;
  import pnz_pkg::*;

  localparam int  FRAC   = 16;
  localparam longint ONE = longint'(1) <<< FRAC;
  localparam longint NOISE_MAX = 524287;
  localparam longint NOISE_MIN = -524288;
  localparam int  N_RANDOM = 730;
  localparam int  N_DIR    = 14;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      cmd;
  logic [HASH_W-1:0]         table_index;
  logic [HASH_W-1:0]         table_value;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [OUT_W-1:0]   noise_value;

  perlin_noise_eval u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .table_index (table_index),
    .table_value (table_value),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .noise_value (noise_value)
  );

  // one row of the directed stimulus; fixed marks a result typed in by hand
  typedef struct {
    logic                      op;
    logic [HASH_W-1:0]         idx;
    logic [HASH_W-1:0]         val;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    bit                        fixed;
    logic signed [OUT_W-1:0]   noise;
  } dir_row_t;

  dir_row_t                dir_rows [N_DIR];
  logic [HASH_W-1:0]       perm_copy [256];   // our own copy of the table
  logic signed [OUT_W-1:0] noise_queue [$];   // expected noise words, oldest first
  int                      mismatches;
  bit                      quiet;             // no idling on either side

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    #50ms;
    $display("[perlin_noise_eval] ERROR");
    $finish;
  end

  task automatic report(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // noise predictor, fixed point with ties rounded away from zero
  // ---------------------------------------------------------------------------
  function automatic longint round_q(input longint v, input int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -(((-v) + half) >>> s);
  endfunction

  function automatic longint mul_fix(input longint a, input longint b);
    return round_q(a * b, FRAC);
  endfunction

  // quintic fade 6t^5 - 15t^4 + 10t^3, in the same product order as the block
  function automatic longint fade_fix(input longint t);
    longint t2, t3, u;
    t2 = mul_fix(t, t);
    t3 = mul_fix(t2, t);
    u  = mul_fix(t, FADE_C6 * t - FADE_C15 * ONE) + FADE_C10 * ONE;
    return mul_fix(t3, u);
  endfunction

  function automatic longint lerp_fix(input longint t, input longint a, input longint b);
    return a + mul_fix(t, b - a);
  endfunction

  // 16-way gradient with z = 0
  function automatic longint grad_fix(input logic [HASH_W-1:0] hash, input longint gx,
                                      input longint gy);
    logic [3:0] h;
    longint a, b;
    h = hash[3:0];
    a = (h < 4'd8) ? gx : gy;
    if (h < 4'd4) b = gy;
    else if (h != GRAD_XX_A && h != GRAD_XX_B) b = 0;
    else b = gx;
    return (h[0] ? -a : a) + (h[1] ? -b : b);
  endfunction

  // integer part truncated toward zero, then wrapped to the table
  function automatic logic [7:0] cell_of(input longint c);
    longint mag;
    mag = (c < 0) ? -c : c;
    mag = mag >>> FRAC;
    if (c < 0) mag = -mag;
    return mag[7:0];
  endfunction

  function automatic logic [7:0] perm_rd(input longint i);
    logic [7:0] k;
    k = i[7:0];
    return perm_copy[k];
  endfunction

  function automatic logic signed [OUT_W-1:0] noise_at(input logic signed [COORD_W-1:0] xs,
                                                       input logic signed [COORD_W-1:0] ys);
    longint xc, yc, fx, fy, xd, yd, g0, g1, l1, l2, r;
    logic [7:0] ix, iy, ha, hb, aaa, aba, baa, bba;
    xc = xs;
    yc = ys;
    ix = cell_of(xc);
    iy = cell_of(yc);
    // fraction comes from the floor, even for negative inputs
    fx = xc & (ONE - 1);
    fy = yc & (ONE - 1);
    xd = fade_fix(fx);
    yd = fade_fix(fy);
    ha  = perm_rd(ix);
    hb  = perm_rd(longint'(ix) + 1);
    aaa = perm_rd(perm_rd(longint'(ha) + iy));
    aba = perm_rd(perm_rd(longint'(ha) + iy + 1));
    baa = perm_rd(perm_rd(longint'(hb) + iy));
    bba = perm_rd(perm_rd(longint'(hb) + iy + 1));
    g0 = grad_fix(aaa, fx, fy);
    g1 = grad_fix(baa, fx - ONE, fy);
    l1 = lerp_fix(xd, g0, g1);
    g0 = grad_fix(aba, fx, fy - ONE);
    g1 = grad_fix(bba, fx - ONE, fy - ONE);
    l2 = lerp_fix(xd, g0, g1);
    r  = lerp_fix(yd, l1, l2);
    // saturate to Q3.16
    if (r > NOISE_MAX) r = NOISE_MAX;
    if (r < NOISE_MIN) r = NOISE_MIN;
    return r[OUT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // input side: drive one word, idling at random first, hold it until taken
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic op, input logic [7:0] idx, input logic [7:0] val,
                           input logic signed [31:0] xs, input logic signed [31:0] ys,
                           input bit fixed, input logic signed [OUT_W-1:0] typed);
    while (!quiet && $urandom_range(99) < 7) begin
      in_valid    <= 1'b0;
      table_index <= 8'($urandom);
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= op;
    table_index <= idx;
    table_value <= val;
    x_coord     <= xs;
    y_coord     <= ys;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    // word taken at this edge: update the table copy or queue the noise word
    if (op == CMD_LOAD) begin
      perm_copy[idx] = val;
    end else begin
      noise_queue.push_back(noise_at(xs, ys));
      if (fixed && noise_at(xs, ys) != typed)
        report($sformatf("typed result %0d disagrees with predictor %0d",
                         typed, noise_at(xs, ys)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stall, check every accepted word against the queue
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (noise_queue.size() == 0) begin
          report($sformatf("unexpected noise word %0d", noise_value));
        end else begin
          if (noise_value !== noise_queue[0])
            report($sformatf("noise got %0d want %0d", noise_value, noise_queue[0]));
          void'(noise_queue.pop_front());
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < 7);
    end
  end

  // a random coordinate, biased toward the interesting corners
  function automatic logic signed [31:0] pick_coord();
    logic signed [31:0] c;
    case ($urandom_range(5))
      0: c = $urandom;                                      // anywhere
      1: c = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000; // near zero
      2: c = {16'($urandom_range(65535)), 16'h0000};        // on a lattice point
      3: c = {16'($urandom_range(65535)), 16'hFFFF};        // just below one
      4: c = -$signed($urandom_range(32'h7FFF_FFFF));       // negative
      default: c = {16'($urandom_range(65535)), 16'h8000};  // half way
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int k;
    rst         = 1'b1;
    in_valid    = 1'b0;
    cmd         = CMD_LOAD;
    table_index = '0;
    table_value = '0;
    x_coord     = '0;
    y_coord     = '0;
    quiet       = 1'b0;
    mismatches  = 0;

    // directed rows: lattice points give zero whatever the table holds
    dir_rows[0]  = '{CMD_LOAD, 8'd0,   8'd255, 32'sh0,          32'sh0,          0, 0};
    dir_rows[1]  = '{CMD_LOAD, 8'd255, 8'd0,   32'sh7FFF_FFFF, -32'sh1,          0, 0};
    dir_rows[2]  = '{CMD_EVAL, 8'hFF,  8'hFF,  32'sh0,          32'sh0,          1, 0};
    dir_rows[3]  = '{CMD_EVAL, 8'h00,  8'h00,  32'sh8000_0000,  32'sh8000_0000,  1, 0};
    dir_rows[4]  = '{CMD_EVAL, 8'h5A,  8'hA5,  32'sh7FFF_0000,  32'sh7FFF_0000,  1, 0};
    dir_rows[5]  = '{CMD_EVAL, 8'hA5,  8'h5A, -32'sh0001_0000,  32'sh00FF_0000,  1, 0};
    // everything else against the predictor
    dir_rows[6]  = '{CMD_EVAL, 8'h00,  8'h00,  32'sh7FFF_FFFF,  32'sh7FFF_FFFF,  0, 0};
    dir_rows[7]  = '{CMD_EVAL, 8'h00,  8'h00, -32'sh1,         -32'sh1,          0, 0};
    dir_rows[8]  = '{CMD_EVAL, 8'h00,  8'h00,  32'sh0000_8000,  32'sh0000_8000,  0, 0};
    dir_rows[9]  = '{CMD_EVAL, 8'h00,  8'h00, -32'sh0001_8000,  32'sh0002_4000,  0, 0};
    dir_rows[10] = '{CMD_EVAL, 8'h00,  8'h00,  32'sh00FF_C000, -32'sh7FFF_4000,  0, 0};
    dir_rows[11] = '{CMD_LOAD, 8'd17,  8'd129, 32'sh0,          32'sh0,          0, 0};
    dir_rows[12] = '{CMD_EVAL, 8'h00,  8'h00,  32'sh0011_3000,  32'sh0010_D000,  0, 0};
    dir_rows[13] = '{CMD_EVAL, 8'h00,  8'h00,  32'sh0000_0001,  32'sh0000_FFFF,  0, 0};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole table so no eval ever reads an unwritten entry
    for (k = 0; k < 256; k++)
      send_word(CMD_LOAD, k[7:0], 8'($urandom), $urandom, $urandom, 0, 0);

    for (k = 0; k < N_DIR; k++)
      send_word(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].val, dir_rows[k].x,
                dir_rows[k].y, dir_rows[k].fixed, dir_rows[k].noise);

    // random mix: mostly evals, some table rewrites
    for (k = 0; k < N_RANDOM; k++) begin
      quiet = (k >= 400 && k < 550);
      if ($urandom_range(99) < 25)
        send_word(CMD_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom, 0, 0);
      else
        send_word(CMD_EVAL, 8'($urandom), 8'($urandom), pick_coord(), pick_coord(), 0, 0);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (noise_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && noise_queue.size() == 0)
      $display("[perlin_noise_eval] OK");
    else
      $display("[perlin_noise_eval] ERROR");
    $finish;
  end

endmodule

FILE: files.f
src/pnz_pkg.sv
src/pnz_ram.sv
src/perlin_noise_eval.sv
tb/sv/perlin_noise_eval_test.sv
